/* rtl/lzd_pkg.sv */
// Shared constants for the LZSS decoder with a 4096-byte history ring.
package lzd_pkg;

    localparam int unsigned RING_DEPTH = 4096;
    localparam int unsigned RING_AW    = $clog2(RING_DEPTH);
    localparam int unsigned MAX_MATCH  = 18;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned OLEN_W     = 24;
    localparam int unsigned LEN_W      = $clog2(MAX_MATCH + 1);
    localparam int unsigned FLAG_CNT_W = 4;

    localparam logic [BYTE_W-1:0]     SPACE_BYTE  = 8'h20;
    localparam logic [RING_AW-1:0]    MATCH_BIAS  = 12'h012;
    localparam logic [LEN_W-1:0]      MIN_MATCH   = LEN_W'(3);
    localparam logic [FLAG_CNT_W-1:0] CODES_PER_FLAG = FLAG_CNT_W'(8);

endpackage

/* rtl/lzd_ifs.sv */
// Valid/ready channel interfaces for compressed input, decoded output and configuration.
interface lzd_in_if;
    logic                        valid;
    logic                        ready;
    logic [lzd_pkg::BYTE_W-1:0]  in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface lzd_out_if;
    logic                        valid;
    logic                        ready;
    logic [lzd_pkg::BYTE_W-1:0]  out_byte;
    logic                        last;
    logic                        overflow_error;

    modport source (output valid, output out_byte, output last, output overflow_error,
                    input ready);
    modport sink   (input valid, input out_byte, input last, input overflow_error,
                    output ready);
endinterface

interface lzd_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [lzd_pkg::OLEN_W-1:0]  output_length;

    modport source (output valid, output output_length, input ready);
    modport sink   (input valid, input output_length, output ready);
endinterface

/* rtl/lzss_decoder_4k_window.sv */
// LZSS decoder top level: flag/literal/match parser, 4096-byte history ring and copy sequencer.
// Flag bytes, literals and the low byte of a match are parsed as they are accepted; a literal
// is registered as its output beat when it is accepted. The high byte of a match checks the
// length and starts the ring read, then the copy sequencer moves one byte per cycle while the
// output side does not stall, through the ring's one read port and one write port, so a match
// of n bytes (3 to 18) holds the input until its copy is done. An overflowing match gives its
// error beat at once. A write of output_length starts a new session and is registered: ring
// entries not yet written in the session read as spaces.
module lzss_decoder_4k_window (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lzd_in_if.sink      i_in,
    lzd_out_if.source   o_out,
    lzd_cfg_if.sink     i_cfg
);
    import lzd_pkg::*;

    typedef enum logic [1:0] {PH_FLAG, PH_CODE, PH_HIGH} t_phase;
    typedef enum logic {S_IDLE, S_COPY} t_state;

    logic [BYTE_W-1:0] r_ring [RING_DEPTH];

    t_state                r_state,      n_state;
    t_phase                r_phase,      n_phase;
    logic [BYTE_W-1:0]     r_flag_bits,  n_flag_bits;
    logic [FLAG_CNT_W-1:0] r_flags_left, n_flags_left;
    logic [BYTE_W-1:0]     r_low,        n_low;
    logic [OLEN_W-1:0]     r_produced,   n_produced;
    logic [OLEN_W-1:0]     r_olen;
    logic                  r_halted,     n_halted;
    logic [LEN_W-1:0]      r_left,       n_left;
    logic [RING_AW-1:0]    r_addr;
    logic [BYTE_W-1:0]     r_q;
    logic                  r_fill;
    logic                  r_fwd;
    logic [BYTE_W-1:0]     r_fwd_data;
    logic                  r_out_valid,  n_out_valid;
    logic [BYTE_W-1:0]     r_out_byte,   n_out_byte;
    logic                  r_out_last,   n_out_last;
    logic                  r_out_err,    n_out_err;

    logic                  can_load;
    logic                  in_ready;
    logic                  in_take;
    logic [BYTE_W-1:0]     in_b;
    logic [LEN_W-1:0]      match_len;
    logic [RING_AW-1:0]    src_in;
    logic [OLEN_W:0]       need_len;
    logic                  overflow;
    logic [OLEN_W-1:0]     prod_inc;
    logic                  fin;
    logic [BYTE_W-1:0]     copy_byte;
    logic                  copy_go;
    logic [RING_AW-1:0]    rd_addr;
    logic [RING_AW-1:0]    wr_addr;
    logic                  wr_en;
    logic [BYTE_W-1:0]     wr_data;
    logic                  n_fill;
    logic                  n_fwd;

    assign can_load  = !r_out_valid || o_out.ready;
    assign in_ready  = (r_state == S_IDLE) && can_load;
    assign in_take   = i_in.valid && in_ready && !r_halted;
    assign in_b      = i_in.in_byte;
    assign match_len = LEN_W'(in_b[3:0]) + MIN_MATCH;
    assign src_in    = {in_b[7:4], r_low} + MATCH_BIAS;
    assign need_len  = {1'b0, r_produced} + (OLEN_W+1)'(match_len);
    assign overflow  = need_len > {1'b0, r_olen};
    assign prod_inc  = r_produced + OLEN_W'(1);
    assign fin       = (prod_inc == r_olen);
    assign copy_byte = r_fwd ? r_fwd_data : (r_fill ? r_q : SPACE_BYTE);
    assign copy_go   = (r_state == S_COPY) && can_load;
    assign wr_addr   = r_produced[RING_AW-1:0];

    assign i_in.ready           = in_ready;
    assign i_cfg.ready          = 1'b1;
    assign o_out.valid          = r_out_valid;
    assign o_out.out_byte       = r_out_byte;
    assign o_out.last           = r_out_last;
    assign o_out.overflow_error = r_out_err;

    always_comb begin
        n_state      = r_state;
        n_phase      = r_phase;
        n_flag_bits  = r_flag_bits;
        n_flags_left = r_flags_left;
        n_low        = r_low;
        n_produced   = r_produced;
        n_halted     = r_halted;
        n_left       = r_left;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_byte   = r_out_byte;
        n_out_last   = r_out_last;
        n_out_err    = r_out_err;
        wr_en        = 1'b0;
        wr_data      = in_b;
        rd_addr      = r_addr;

        case (r_state)
            S_IDLE: begin
                rd_addr = src_in;
                if (in_take) begin
                    case (r_phase)
                        PH_FLAG: begin
                            n_flag_bits  = in_b;
                            n_flags_left = CODES_PER_FLAG;
                            n_phase      = PH_CODE;
                        end
                        PH_CODE: begin
                            if (r_flag_bits[0]) begin
                                n_flag_bits  = r_flag_bits >> 1;
                                n_flags_left = r_flags_left - FLAG_CNT_W'(1);
                                n_phase      = (r_flags_left == FLAG_CNT_W'(1)) ? PH_FLAG
                                                                                : PH_CODE;
                                wr_en        = 1'b1;
                                n_out_valid  = 1'b1;
                                n_out_byte   = in_b;
                                n_out_last   = fin;
                                n_out_err    = 1'b0;
                                n_produced   = prod_inc;
                                n_halted     = fin;
                            end else begin
                                n_low   = in_b;
                                n_phase = PH_HIGH;
                            end
                        end
                        default: begin
                            n_flag_bits  = r_flag_bits >> 1;
                            n_flags_left = r_flags_left - FLAG_CNT_W'(1);
                            n_phase      = (r_flags_left == FLAG_CNT_W'(1)) ? PH_FLAG : PH_CODE;
                            if (overflow) begin
                                n_out_valid = 1'b1;
                                n_out_byte  = '0;
                                n_out_last  = 1'b1;
                                n_out_err   = 1'b1;
                                n_halted    = 1'b1;
                            end else begin
                                n_left  = match_len;
                                n_state = S_COPY;
                            end
                        end
                    endcase
                end
            end
            default: begin
                if (copy_go) begin
                    rd_addr     = r_addr + RING_AW'(1);
                    wr_en       = 1'b1;
                    wr_data     = copy_byte;
                    n_out_valid = 1'b1;
                    n_out_byte  = copy_byte;
                    n_out_last  = fin;
                    n_out_err   = 1'b0;
                    n_produced  = prod_inc;
                    n_halted    = fin;
                    n_left      = r_left - LEN_W'(1);
                    if (fin || r_left == LEN_W'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
        endcase
    end

    // Entries at or past the fill point of this session read as spaces.
    assign n_fill = (r_produced[OLEN_W-1:RING_AW] != '0) || (rd_addr < wr_addr);
    assign n_fwd  = wr_en && (rd_addr == wr_addr);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_ring[wr_addr] <= wr_data;
        end
        r_q <= r_ring[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        r_addr     <= rd_addr;
        r_fill     <= n_fill;
        r_fwd      <= n_fwd;
        r_fwd_data <= wr_data;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
        r_out_err  <= n_out_err;
        r_low      <= n_low;
        r_left     <= n_left;
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_phase      <= PH_FLAG;
            r_flag_bits  <= '0;
            r_flags_left <= '0;
            r_produced   <= '0;
            r_olen       <= '0;
            r_halted     <= 1'b1;
            r_out_valid  <= 1'b0;
        end else if (i_cfg.valid) begin
            r_state      <= S_IDLE;
            r_phase      <= PH_FLAG;
            r_flag_bits  <= '0;
            r_flags_left <= '0;
            r_produced   <= '0;
            r_olen       <= i_cfg.output_length;
            r_halted     <= (i_cfg.output_length == '0);
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_phase      <= n_phase;
            r_flag_bits  <= n_flag_bits;
            r_flags_left <= n_flags_left;
            r_produced   <= n_produced;
            r_halted     <= n_halted;
            r_out_valid  <= n_out_valid;
        end
    end

    a_copy_not_halted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_COPY |-> !r_halted)
        else $error("copy running in a halted session");

    a_copy_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_COPY |-> (r_left != '0) && (r_left <= LEN_W'(MAX_MATCH)))
        else $error("copy length out of range");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_produced <= r_olen)
        else $error("produced count passed output length");

    a_err_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_err |-> r_out_last && (r_out_byte == '0))
        else $error("error beat not final or not zero");

    a_last_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && o_out.ready && r_out_last |=> r_halted)
        else $error("session still active after final beat");

endmodule

/* tb/sv/lzss_decoder_4k_window_tb.sv */
`timescale 1ns / 1ps
// Testbench for the LZSS decoder: drives byte streams, predicts every decoded beat and checks it.
module lzss_decoder_4k_window_tb;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_ITEMS  = 100;
    localparam int SESSION_CAP   = 48;

    typedef enum logic [1:0] {
        PARSE_FLAG,
        PARSE_CODE,
        PARSE_HIGH
    } t_parse;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       overflow;
    } t_beat;

    class lzss_decode_sb;
        logic [7:0]  history [lzd_pkg::RING_DEPTH];
        logic [7:0]  flag_reg;
        int          codes_left;
        t_parse      phase;
        logic [7:0]  low_byte;
        logic [23:0] produced;
        logic [23:0] target_len;
        bit          finished;
        t_beat       expected_bytes[$];
        int          errors;

        function void new_session(logic [23:0] len);
            target_len = len;
            foreach (history[i]) history[i] = lzd_pkg::SPACE_BYTE;
            flag_reg   = '0;
            codes_left = 0;
            phase      = PARSE_FLAG;
            low_byte   = '0;
            produced   = '0;
            finished   = 1'b0;
        endfunction

        function bit session_over();
            return finished || (produced >= target_len);
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction

        function void queue_beat(t_beat bt);
            expected_bytes.insert(expected_bytes.size(), bt);
        endfunction

        function void next_code();
            flag_reg   = flag_reg >> 1;
            codes_left = codes_left - 1;
            phase      = (codes_left == 0) ? PARSE_FLAG : PARSE_CODE;
        endfunction

        function bit put_byte(logic [7:0] b);
            bit fin;
            history[produced[11:0]] = b;
            produced = produced + 24'd1;
            fin = (produced >= target_len);
            queue_beat('{data: b, last: fin, overflow: 1'b0});
            if (fin) finished = 1'b1;
            return fin;
        endfunction

        // Returns 1 when the byte is consumed by the parser, 0 when it is dropped.
        function bit take_input(logic [7:0] b);
            int         run;
            logic [11:0] src;
            if (session_over()) return 1'b0;
            case (phase)
                PARSE_FLAG: begin
                    flag_reg   = b;
                    codes_left = int'(lzd_pkg::CODES_PER_FLAG);
                    phase      = PARSE_CODE;
                end
                PARSE_CODE: begin
                    if (flag_reg[0]) begin
                        next_code();
                        void'(put_byte(b));
                    end else begin
                        low_byte = b;
                        phase    = PARSE_HIGH;
                    end
                end
                default: begin
                    run = int'(b[3:0]) + int'(lzd_pkg::MIN_MATCH);
                    src = {b[7:4], low_byte} + lzd_pkg::MATCH_BIAS;
                    next_code();
                    if (int'(produced) + run > int'(target_len)) begin
                        queue_beat('{data: 8'h00, last: 1'b1, overflow: 1'b1});
                        finished = 1'b1;
                    end else begin
                        for (int k = 0; k < run; k++) begin
                            if (put_byte(history[src + 12'(k)])) break;
                        end
                    end
                end
            endcase
            return 1'b1;
        endfunction

        task report(string msg);
            $display("ERROR at %0t ns: %s", $time, msg);
            errors++;
        endtask

        task check_beat(logic [7:0] d, logic l, logic e);
            t_beat want;
            if (expected_bytes.size() == 0) begin
                report($sformatf("unexpected beat data=%02h last=%0b ovf=%0b", d, l, e));
            end else begin
                want = expected_bytes.pop_front();
                if (d !== want.data)
                    report($sformatf("out_byte %02h, expected %02h", d, want.data));
                if (l !== want.last)
                    report($sformatf("last %0b, expected %0b", l, want.last));
                if (e !== want.overflow)
                    report($sformatf("overflow_error %0b, expected %0b", e, want.overflow));
            end
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    lzd_in_if  in_if ();
    lzd_out_if out_if ();
    lzd_cfg_if cfg_if ();

    lzss_decoder_4k_window dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    lzss_decode_sb sb;
    int            consumed_items;
    int            burst_left;
    int            cycle_count;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Output stall pattern: phases of full rate, coin flips, sparse ready and a rotating mask.
    initial begin
        int         phase_left;
        int         mode;
        int         step;
        logic [7:0] mask;
        logic       rdy;
        phase_left = 0;
        mode       = 0;
        step       = 0;
        mask       = 8'hff;
        out_if.ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (phase_left == 0) begin
                mode       = $urandom_range(0, 3);
                phase_left = $urandom_range(20, 120);
                mask       = 8'($urandom);
            end
            phase_left--;
            step++;
            case (mode)
                0:       rdy = 1'b1;
                1:       rdy = 1'($urandom_range(0, 1));
                2:       rdy = ($urandom_range(0, 3) == 0);
                default: rdy = mask[step % 8];
            endcase
            out_if.ready <= rdy;
        end
    end

    initial begin
        logic [7:0] d;
        logic       l;
        logic       e;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_if.valid && out_if.ready) begin
                d = out_if.out_byte;
                l = out_if.last;
                e = out_if.overflow_error;
                #1;
                sb.check_beat(d, l, e);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        if (burst_left == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? 200 : int'($urandom_range(1, 12));
        end
        in_if.valid   <= 1'b1;
        in_if.in_byte <= b;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        if (sb.take_input(b)) consumed_items++;
        burst_left--;
    endtask

    task automatic write_length(input logic [23:0] len);
        cfg_if.valid         <= 1'b1;
        cfg_if.output_length <= len;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        sb.new_session(len);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic settle();
        in_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_list(input logic [7:0] bytes[$]);
        foreach (bytes[i]) send_byte(bytes[i]);
    endtask

    task automatic send_match();
        logic [11:0] pos;
        int          back_off;
        int          n;
        int          room;
        if (sb.produced > 0 && $urandom_range(0, 9) < 7) begin
            back_off = $urandom_range(1, (sb.produced < 40) ? int'(sb.produced) : 40);
            pos  = 12'(sb.produced) - 12'(back_off) - lzd_pkg::MATCH_BIAS;
        end else begin
            pos = 12'($urandom);
        end
        n    = $urandom_range(0, 15);
        room = int'(sb.target_len) - int'(sb.produced);
        if (room < n + 3 && room >= 3 && $urandom_range(0, 3) != 0)
            n = $urandom_range(0, room - 3);
        send_byte(pos[7:0]);
        if (!sb.session_over()) send_byte({pos[11:8], 4'(n)});
    endtask

    task automatic run_session(input bit noise);
        int         sent;
        logic [7:0] flags;
        sent = 0;
        if (noise) begin
            while (!sb.session_over() && sent < SESSION_CAP) begin
                send_byte(8'($urandom));
                sent++;
            end
        end else begin
            while (!sb.session_over() && sent < SESSION_CAP) begin
                flags = 8'($urandom);
                send_byte(flags);
                sent++;
                for (int i = 0; i < 8 && !sb.session_over(); i++) begin
                    if (flags[i]) begin
                        send_byte(8'($urandom));
                        sent++;
                    end else begin
                        send_match();
                        sent += 2;
                    end
                end
            end
        end
        repeat ($urandom_range(0, 2)) send_byte(8'($urandom));
    endtask

    initial begin
        logic [23:0] len;
        int          pick;
        sb = new();
        sb.errors      = 0;
        consumed_items = 0;
        burst_left    = 0;
        i_rst_n              <= 1'b0;
        in_if.valid          <= 1'b0;
        in_if.in_byte        <= 8'h00;
        cfg_if.valid         <= 1'b0;
        cfg_if.output_length <= 24'h0;
        sb.new_session(24'h0);
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty session after reset: drop everything
        send_list('{8'h81, 8'h7e});
        settle();

        // literals, match from cleared ring, self-overlapping match, overflow, trailing byte
        write_length(24'd30);
        send_list('{8'h13, 8'h00, 8'hff, 8'hff, 8'hf0, 8'hee, 8'hff, 8'h5a,
                    8'h00, 8'h00, 8'h00, 8'h0f, 8'h77});
        settle();

        write_length(24'd1);
        send_list('{8'h00, 8'h34, 8'h00, 8'h12});
        settle();

        write_length(24'd3);
        send_list('{8'h00, 8'h10, 8'h50});
        settle();

        write_length(24'hffffff);
        send_list('{8'hff, 8'h01, 8'h80, 8'h7f});
        settle();

        write_length(24'd0);
        send_list('{8'h00, 8'hff});
        settle();

        consumed_items = 0;
        while (consumed_items < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 19);
            case (pick)
                0:       len = 24'd0;
                1:       len = 24'hffffff;
                2:       len = 24'($urandom_range(100, 400));
                default: len = 24'($urandom_range(1, 60));
            endcase
            write_length(len);
            run_session($urandom_range(0, 9) == 0);
            settle();
        end

        if (sb.pending() != 0)
            sb.report($sformatf("%0d expected beats never arrived", sb.pending()));
        if (sb.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
